// ===== rtl/dns_pkg.sv =====
// Types and constants shared by the decimal number scanner modules.
package dns_pkg;

    localparam int CHAR_W   = 8;
    localparam int MANT_W   = 32;
    localparam int EXP_W    = 16;
    localparam int COUNT_W  = 16;
    localparam int LIMIT_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;

    typedef enum logic [1:0] {
        PH_START,
        PH_BODY,
        PH_EXP_START,
        PH_EXP_DIGITS
    } t_phase;

    typedef struct packed {
        logic [COUNT_W-1:0]       chars_consumed;
        logic signed [EXP_W-1:0]  decimal_exponent;
        logic signed [MANT_W-1:0] mantissa;
        logic                     ender_consumed;
    } t_result;

endpackage

// ===== rtl/decimal_number_scanner.sv =====
// Top level of the decimal number scanner.
// Takes one character per transfer and scans a signed decimal number with an
// optional point and an optional e/E exponent of up to the configured number of
// digits (0 = unlimited). When a character ends the number, or the last allowed
// exponent digit arrives, one result carries the wrapped 32-bit mantissa, the
// saturated decimal exponent, the count of characters in the number and whether
// the ending character belonged to it. A character passes through an input
// register and is scanned once the result register has room, so the block takes one
// character per cycle while no result waits; the scan step of the ending character loads
// the result register, and the stream stalls only while a waiting result is not taken.
module decimal_number_scanner import dns_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,   // exponent_digit_limit
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,    // [7:0] text_char
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata,    // [31:0] mantissa, [47:32] decimal_exponent,
                                                // [63:48] chars_consumed
    output logic               m_axis_tuser     // ender_consumed
);

    logic [LIMIT_W-1:0] r_limit;
    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               step;
    logic               out_free;
    logic               emit;
    t_result            core_result;
    t_result            out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // a character is scanned only when its possible result has a free slot
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
        end
    end

    dns_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_in_char),
        .i_limit  (r_limit),
        .o_emit   (emit),
        .o_result (core_result)
    );

    dns_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (core_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign m_axis_tdata = {out_result.chars_consumed, out_result.decimal_exponent,
                           out_result.mantissa};
    assign m_axis_tuser = out_result.ender_consumed;

endmodule

// ===== rtl/dns_core.sv =====
// Scanner state and the per-character step that updates it and forms a result.
module dns_core import dns_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [CHAR_W-1:0]  i_char,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_emit,
    output t_result            o_result
);

    t_phase              r_phase,      n_phase;
    logic [MANT_W-1:0]   r_acc,        n_acc;
    logic [COUNT_W-1:0]  r_frac,       n_frac;
    logic                r_point,      n_point;
    logic                r_body,       n_body;
    logic                r_mneg,       n_mneg;
    logic [EXP_W-1:0]    r_eacc,       n_eacc;
    logic                r_eneg,       n_eneg;
    logic [LIMIT_W-1:0]  r_ecnt,       n_ecnt;
    logic [COUNT_W-1:0]  r_count,      n_count;

    logic                      is_digit;
    logic                      is_sign;
    logic                      is_e;
    logic [3:0]                digit;
    logic [EXP_W+3:0]          eacc_wide;
    logic signed [EXP_W+1:0]   exp_full;
    logic                      emit;
    logic                      ender;
    t_result                   res;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_sign  = (i_char == CH_MINUS) || (i_char == CH_PLUS);
    assign is_e     = (i_char == CH_LOW_E) || (i_char == CH_UP_E);
    assign digit    = i_char[3:0];
    assign eacc_wide = ({4'd0, r_eacc} << 3) + ({4'd0, r_eacc} << 1) + {16'd0, digit};

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_frac  = r_frac;
        n_point = r_point;
        n_body  = r_body;
        n_mneg  = r_mneg;
        n_eacc  = r_eacc;
        n_eneg  = r_eneg;
        n_ecnt  = r_ecnt;
        n_count = r_count;
        emit    = 1'b0;
        ender   = 1'b0;
        exp_full = '0;
        res     = '0;

        case (r_phase)
            PH_START, PH_BODY: begin
                if (r_phase == PH_START && is_sign) begin
                    n_phase = PH_BODY;
                    n_mneg  = (i_char == CH_MINUS);
                    n_count = r_count + COUNT_W'(r_count != '1);
                end else if (is_digit) begin
                    n_phase = PH_BODY;
                    n_acc   = (r_acc << 3) + (r_acc << 1) + {28'd0, digit};
                    n_frac  = r_frac + COUNT_W'(r_point && (r_frac != '1));
                    n_body  = 1'b1;
                    n_count = r_count + COUNT_W'(r_count != '1);
                end else if (i_char == CH_POINT && !r_point) begin
                    n_phase = PH_BODY;
                    n_point = 1'b1;
                    n_body  = 1'b1;
                    n_count = r_count + COUNT_W'(r_count != '1);
                end else if (r_body && is_e) begin
                    n_phase = PH_EXP_START;
                    n_count = r_count + COUNT_W'(r_count != '1);
                end else begin
                    emit = 1'b1;
                end
            end
            PH_EXP_START, PH_EXP_DIGITS: begin
                n_phase = PH_EXP_DIGITS;
                if (r_phase == PH_EXP_START && is_sign) begin
                    n_eneg  = (i_char == CH_MINUS);
                    n_count = r_count + COUNT_W'(r_count != '1);
                end else if (is_digit && (i_limit == '0 || r_ecnt < i_limit)) begin
                    n_eacc  = (eacc_wide > {4'd0, {EXP_W{1'b1}}}) ? '1 : eacc_wide[EXP_W-1:0];
                    n_ecnt  = r_ecnt + LIMIT_W'(r_ecnt != '1);
                    n_count = r_count + COUNT_W'(r_count != '1);
                    if (i_limit != '0 && n_ecnt >= i_limit) begin
                        emit  = 1'b1;
                        ender = 1'b1;
                    end
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
                n_phase = PH_START;
            end
        endcase

        // result is formed from the updated state, then the number is cleared
        if (emit) begin
            exp_full = n_eneg ? -$signed({2'b00, n_eacc}) : $signed({2'b00, n_eacc});
            exp_full = exp_full - $signed({2'b00, n_frac});
            if (exp_full > 18'sd32767) begin
                res.decimal_exponent = 16'sh7FFF;
            end else if (exp_full < -18'sd32768) begin
                res.decimal_exponent = 16'sh8000;
            end else begin
                res.decimal_exponent = exp_full[EXP_W-1:0];
            end
            res.mantissa       = n_mneg ? (32'd0 - n_acc) : n_acc;
            res.chars_consumed = n_count;
            res.ender_consumed = ender;
            n_phase = PH_START;
            n_acc   = '0;
            n_frac  = '0;
            n_point = 1'b0;
            n_body  = 1'b0;
            n_mneg  = 1'b0;
            n_eacc  = '0;
            n_eneg  = 1'b0;
            n_ecnt  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_acc   <= '0;
            r_frac  <= '0;
            r_point <= 1'b0;
            r_body  <= 1'b0;
            r_mneg  <= 1'b0;
            r_eacc  <= '0;
            r_eneg  <= 1'b0;
            r_ecnt  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_body  <= n_body;
            r_mneg  <= n_mneg;
            r_eacc  <= n_eacc;
            r_eneg  <= n_eneg;
            r_ecnt  <= n_ecnt;
            r_count <= n_count;
        end
    end

    assign o_emit   = i_step && emit;
    assign o_result = res;

endmodule

// ===== rtl/dns_out_reg.sv =====
// Result register holding one finished number until the downstream side takes it.
module dns_out_reg import dns_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/dns_checker.sv =====
// Port-level checks for the decimal number scanner, bound to the top level.
module dns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a consumed ending character is always counted
    a_ender_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[63:48] != 16'd0)
        else $error("consumed ender with zero character count");

    // an empty number carries a zero mantissa and exponent
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[63:48] == 16'd0 |-> m_axis_tdata[47:0] == 48'd0)
        else $error("empty number with nonzero value");

endmodule

bind decimal_number_scanner dns_checker u_dns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/tb_decimal_number_scanner.sv =====
// Self-checking testbench for the decimal number scanner.
module tb_decimal_number_scanner;
    import dns_pkg::*;

    typedef struct packed {
        logic [7:0]         ch;
        logic               typed;
        logic signed [31:0] mant;
        logic signed [15:0] expo;
        logic [15:0]        count;
        logic               ender;
    } t_text_row;

    // rows with typed = 1 carry the number they close; every row also goes to the scan model
    localparam t_text_row DIRECTED_TEXT [0:27] = '{
        '{8'h00,    1'b1, 32'sd0,   16'sd0,    16'd0, 1'b0},  // end of string, empty number
        '{CH_MINUS, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"9",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_POINT, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"5",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_LOW_E, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_MINUS, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"1",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"2",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"3",      1'b1, -32'sd95, -16'sd124, 16'd9, 1'b1},  // last exponent digit closes
        '{CH_PLUS,  1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"7",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{"x",      1'b1, 32'sd7,   16'sd0,    16'd2, 1'b0},
        '{CH_LOW_E, 1'b1, 32'sd0,   16'sd0,    16'd0, 1'b0},  // bare exponent mark
        '{"1",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_POINT, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_POINT, 1'b1, 32'sd1,   16'sd0,    16'd2, 1'b0},  // second point
        '{"5",      1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_UP_E,  1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_PLUS,  1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{8'h00,    1'b1, 32'sd5,   16'sd0,    16'd3, 1'b0},  // exponent with no digits
        '{8'hFF,    1'b1, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_POINT, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{" ",      1'b1, 32'sd0,   16'sd0,    16'd1, 1'b0},
        '{CH_MINUS, 1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_MINUS, 1'b1, 32'sd0,   16'sd0,    16'd1, 1'b0},  // sign only leads
        '{CH_PLUS,  1'b0, 32'sd0,   16'sd0,    16'd0, 1'b0},
        '{CH_UP_E,  1'b1, 32'sd0,   16'sd0,    16'd1, 1'b0}
    };

    localparam logic [1:0] LIMIT_ORDER [0:3] = '{2'd2, 2'd0, 2'd1, 2'd3};
    localparam logic [7:0] NUMBER_CHARS [0:6] =
        '{CH_MINUS, CH_PLUS, CH_POINT, CH_LOW_E, CH_UP_E, CH_ZERO, CH_NINE};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [63:0]        m_axis_tdata;
    logic               m_axis_tuser;

    decimal_number_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // scan model state
    logic [1:0]  digit_limit;
    t_phase      scan_ph;
    logic [31:0] mant_acc;
    logic [15:0] frac_cnt;
    logic        point_seen;
    logic        body_seen;
    logic        mant_neg;
    logic [15:0] exp_acc;
    logic        exp_neg;
    logic [1:0]  exp_cnt;
    logic [15:0] char_cnt;

    t_result pending_numbers [$];
    int      fail_count = 0;
    int      chars_sent = 0;
    int      tx_idle_pct = 15;
    int      rx_idle_pct = 74;
    logic    pressure_go = 1'b0;
    logic    rx_stalled = 1'b0;

    function automatic void restart_scan();
        scan_ph    = PH_START;
        mant_acc   = '0;
        frac_cnt   = '0;
        point_seen = 1'b0;
        body_seen  = 1'b0;
        mant_neg   = 1'b0;
        exp_acc    = '0;
        exp_neg    = 1'b0;
        exp_cnt    = '0;
        char_cnt   = '0;
    endfunction

    function automatic void bump_char_count();
        if (char_cnt != 16'hFFFF) char_cnt++;
    endfunction

    function automatic t_result close_number(input logic ender);
        t_result num;
        int      e;
        num.mantissa = mant_neg ? (32'd0 - mant_acc) : mant_acc;
        e = int'(exp_acc);
        if (exp_neg) e = -e;
        e -= int'(frac_cnt);
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        num.decimal_exponent = e[15:0];
        num.chars_consumed   = char_cnt;
        num.ender_consumed   = ender;
        restart_scan();
        return num;
    endfunction

    // advances the scan by one character; returns 1 when a number closes
    function automatic logic scan_char(input logic [7:0] c, output t_result num);
        logic        is_digit;
        logic [31:0] wide;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        num = '0;
        if (scan_ph == PH_START) begin
            scan_ph = PH_BODY;
            if (c == CH_MINUS || c == CH_PLUS) begin
                mant_neg = (c == CH_MINUS);
                bump_char_count();
                return 1'b0;
            end
        end
        if (scan_ph == PH_BODY) begin
            if (is_digit) begin
                mant_acc = mant_acc * 32'd10 + 32'(c - CH_ZERO);
                if (point_seen && frac_cnt != 16'hFFFF) frac_cnt++;
                body_seen = 1'b1;
                bump_char_count();
                return 1'b0;
            end
            if (c == CH_POINT && !point_seen) begin
                point_seen = 1'b1;
                body_seen  = 1'b1;
                bump_char_count();
                return 1'b0;
            end
            if (body_seen && (c == CH_LOW_E || c == CH_UP_E)) begin
                scan_ph = PH_EXP_START;
                bump_char_count();
                return 1'b0;
            end
            num = close_number(1'b0);
            return 1'b1;
        end
        if (scan_ph == PH_EXP_START) begin
            scan_ph = PH_EXP_DIGITS;
            if (c == CH_MINUS || c == CH_PLUS) begin
                exp_neg = (c == CH_MINUS);
                bump_char_count();
                return 1'b0;
            end
        end
        scan_ph = PH_EXP_DIGITS;
        if (is_digit && (digit_limit == 2'd0 || exp_cnt < digit_limit)) begin
            wide = 32'(exp_acc) * 32'd10 + 32'(c - CH_ZERO);
            exp_acc = (wide > 32'd65535) ? 16'hFFFF : wide[15:0];
            if (exp_cnt != 2'd3) exp_cnt++;
            bump_char_count();
            if (digit_limit != 2'd0 && exp_cnt >= digit_limit) begin
                num = close_number(1'b1);
                return 1'b1;
            end
            return 1'b0;
        end
        num = close_number(1'b0);
        return 1'b1;
    endfunction

    // offers one character; tvalid stays high afterwards unless a gap follows
    task automatic send_char(input logic [7:0] c, input logic typed = 1'b0,
                             input t_result typed_num = '0);
        t_result num;
        logic    closed;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
        closed = scan_char(c, num);
        if (closed) pending_numbers.push_back(typed ? typed_num : num);
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++) send_char(txt[k]);
    endtask

    task automatic send_digits(input int n);
        repeat (n) send_char(CH_ZERO + 8'($urandom_range(9)));
    endtask

    // only while nothing is outstanding; the last character may still be in flight
    task automatic load_digit_limit(input logic [1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        digit_limit = value;
    endtask

    // mostly well-formed numbers with random content, some noise
    task automatic send_random_number();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)));
            return;
        end
        if ($urandom_range(2) == 0) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(9) == 0) begin
            if ($urandom_range(1)) repeat ($urandom_range(10, 12)) send_char(CH_NINE);
            else send_digits($urandom_range(8, 12));
        end else begin
            send_digits($urandom_range(0, 4));
        end
        if ($urandom_range(1)) begin
            send_char(CH_POINT);
            send_digits($urandom_range(0, 4));
        end
        if ($urandom_range(99) < 60) begin
            send_char($urandom_range(1) ? CH_LOW_E : CH_UP_E);
            if ($urandom_range(1)) send_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
            if (digit_limit == 2'd0 && $urandom_range(3) == 0) send_digits($urandom_range(5, 7));
            else send_digits($urandom_range(0, 4));
        end
        pick = $urandom_range(3);
        case (pick)
            0: send_char(8'h00);
            1: send_char(" ");
            2: send_char(NUMBER_CHARS[$urandom_range(6)]);
            default: send_char(8'($urandom_range(255)));
        endcase
    endtask

    initial begin : stimulus
        t_result typed_num;
        int      group_end;
        digit_limit = LIMIT_RESET;
        restart_scan();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_TEXT[k]) begin
            typed_num.mantissa         = DIRECTED_TEXT[k].mant;
            typed_num.decimal_exponent = DIRECTED_TEXT[k].expo;
            typed_num.chars_consumed   = DIRECTED_TEXT[k].count;
            typed_num.ender_consumed   = DIRECTED_TEXT[k].ender;
            send_char(DIRECTED_TEXT[k].ch, DIRECTED_TEXT[k].typed, typed_num);
        end

        // unlimited exponent: saturation both ways, then lower the limit mid-number
        load_digit_limit(2'd0);
        send_text("-2e-999999;3e999999 1e12");
        load_digit_limit(2'd1);
        send_text("5");

        for (int g = 0; g < 15; g++) begin
            load_digit_limit(LIMIT_ORDER[g % 4]);
            if (g == 5) begin
                tx_idle_pct = 74;
                rx_idle_pct <= 15;
            end else if (g == 10) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                pressure_go <= 1'b1;
            end
            group_end = chars_sent + 50;
            while (chars_sent < group_end) send_random_number();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_numbers.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // long receiver stall while the sender keeps offering
    initial begin : rx_hold_off
        wait (pressure_go);
        rx_stalled <= 1'b1;
        repeat (120) @(posedge i_clk);
        rx_stalled <= 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct) && !rx_stalled;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_numbers.size() == 0) begin
                $display("%0t unexpected transfer: expected none, actual mantissa %0d",
                         $time, $signed(m_axis_tdata[31:0]));
                fail_count++;
            end else begin
                want = pending_numbers.pop_front();
                if (m_axis_tdata[31:0] !== want.mantissa) begin
                    $display("%0t mantissa: expected %0d, actual %0d", $time,
                             want.mantissa, $signed(m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (m_axis_tdata[47:32] !== want.decimal_exponent) begin
                    $display("%0t decimal_exponent: expected %0d, actual %0d", $time,
                             want.decimal_exponent, $signed(m_axis_tdata[47:32]));
                    fail_count++;
                end
                if (m_axis_tdata[63:48] !== want.chars_consumed) begin
                    $display("%0t chars_consumed: expected %0d, actual %0d", $time,
                             want.chars_consumed, m_axis_tdata[63:48]);
                    fail_count++;
                end
                if (m_axis_tuser !== want.ender_consumed) begin
                    $display("%0t ender_consumed: expected %0d, actual %0d", $time,
                             want.ender_consumed, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule
